// ----- sv/trast_pkg.sv -----
// ----------------------------------------------------------------------------
// Triangle raster interpolator package
// Shared widths, codes and defaults for the raster interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package trast_pkg;

    localparam int COORD_W  = 32;   // Q24.8 coordinates
    localparam int ATTR_W   = 32;   // Q16.16 attributes
    localparam int CELL_W   = 16;   // cell size register
    localparam int CSZ_W    = 24;   // cell size in Q16.8
    localparam int DIFF_W   = 33;   // vertex differences
    localparam int MA_W     = 40;   // serial multiplier operand A
    localparam int MB_W     = 34;   // serial multiplier operand B
    localparam int GEO_W    = 74;   // edge function values
    localparam int DVD_W    = 34;   // bounding box dividend
    localparam int QUO_W    = 35;   // bounding box quotient
    localparam int FRAC_W   = 32;   // barycentric weights, Q0.32
    localparam int CNT_W    = 17;
    localparam int IDX_W    = 8;    // read_col / read_row
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W    = 32;

    localparam int GRID_COLS_DEF = 256;
    localparam int GRID_ROWS_DEF = 256;

    localparam logic OP_DRAW = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X = 2'd0,
        CFG_ORIGIN_Y = 2'd1,
        CFG_CELL_DX  = 2'd2,
        CFG_CELL_DY  = 2'd3
    } t_cfg_reg;

endpackage

`default_nettype wire

// ----- sv/trast_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module trast_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ----- sv/trast_fdiv.sv -----
// ----------------------------------------------------------------------------
// Bounding box floor divider
// Signed dividend over unsigned cell size, one quotient bit per cycle,
// rounded towards minus infinity.
// ----------------------------------------------------------------------------
`default_nettype none

module trast_fdiv (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [trast_pkg::DVD_W-1:0] i_dvd,
    input  wire logic        [trast_pkg::CSZ_W-1:0] i_dvs,
    output logic                                   o_done,
    output logic signed      [trast_pkg::QUO_W-1:0] o_quo
);
    import trast_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_num;
    logic [DVD_W-1:0]  r_q;
    logic [CSZ_W-1:0]  r_rem;
    logic [CSZ_W-1:0]  r_dvs;
    logic              r_neg;

    logic [CSZ_W:0]    w_trial;
    logic              w_ge;
    logic [CSZ_W-1:0]  w_rem;
    logic [QUO_W-1:0]  w_mag;

    assign w_trial = {r_rem, r_num[DVD_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_rem   = w_ge ? CSZ_W'(w_trial - {1'b0, r_dvs}) : CSZ_W'(w_trial);
    assign w_mag   = QUO_W'(r_q) + QUO_W'(r_neg && (r_rem != '0));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_q    <= '0;
                r_dvs  <= i_dvs;
                r_neg  <= i_dvd[DVD_W-1];
                r_num  <= i_dvd[DVD_W-1] ? (~i_dvd + DVD_W'(1)) : i_dvd;
            end else if (r_busy) begin
                r_rem <= w_rem;
                r_num <= {r_num[DVD_W-2:0], 1'b0};
                r_q   <= {r_q[DVD_W-2:0], w_ge};
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? (~w_mag + QUO_W'(1)) : w_mag;

endmodule

`default_nettype wire

// ----- sv/trast_mul.sv -----
// ----------------------------------------------------------------------------
// Setup multiplier
// Signed shift-and-add multiplier, one bit of operand B per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trast_mul (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire logic signed [trast_pkg::MA_W-1:0]  i_a,
    input  wire logic signed [trast_pkg::MB_W-1:0]  i_b,
    output logic                                   o_done,
    output logic signed      [trast_pkg::GEO_W-1:0] o_p
);
    import trast_pkg::*;

    localparam int STEP_W = $clog2(MB_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [GEO_W-1:0]  r_ma;
    logic [MB_W-1:0]   r_mb;
    logic [GEO_W-1:0]  r_acc;
    logic              r_neg;

    logic [MA_W-1:0]   w_ua;
    logic [MB_W-1:0]   w_ub;
    logic [GEO_W-1:0]  w_nacc;

    assign w_ua   = i_a[MA_W-1] ? (~i_a + MA_W'(1)) : i_a;
    assign w_ub   = i_b[MB_W-1] ? (~i_b + MB_W'(1)) : i_b;
    assign w_nacc = ~r_acc + GEO_W'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_acc  <= '0;
                r_ma   <= GEO_W'(w_ua);
                r_mb   <= w_ub;
                r_neg  <= i_a[MA_W-1] ^ i_b[MB_W-1];
            end else if (r_busy) begin
                if (r_mb[0]) begin
                    r_acc <= r_acc + r_ma;
                end
                r_ma  <= {r_ma[GEO_W-2:0], 1'b0};
                r_mb  <= {1'b0, r_mb[MB_W-1:1]};
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(MB_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_neg ? w_nacc : r_acc;

endmodule

`default_nettype wire

// ----- sv/trast_frac.sv -----
// ----------------------------------------------------------------------------
// Weight divider
// floor(2^32 * num / den) for num < den, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module trast_frac (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [trast_pkg::GEO_W-1:0] i_num,
    input  wire logic [trast_pkg::GEO_W-1:0] i_den,
    output logic                             o_done,
    output logic      [trast_pkg::FRAC_W-1:0] o_q
);
    import trast_pkg::*;

    localparam int STEP_W = $clog2(FRAC_W);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [GEO_W-1:0]  r_rem;
    logic [GEO_W-1:0]  r_den;
    logic [FRAC_W-1:0] r_q;

    logic [GEO_W:0]    w_trial;
    logic              w_ge;
    logic [GEO_W-1:0]  w_rem;

    assign w_trial = {r_rem, 1'b0};
    assign w_ge    = w_trial >= {1'b0, r_den};
    assign w_rem   = w_ge ? GEO_W'(w_trial - {1'b0, r_den}) : GEO_W'(w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= i_num;
                r_den  <= i_den;
                r_q    <= '0;
            end else if (r_busy) begin
                r_rem <= w_rem;
                r_q   <= {r_q[FRAC_W-2:0], w_ge};
                r_cnt <= r_cnt + STEP_W'(1);
                if (r_cnt == STEP_W'(FRAC_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_q    = r_q;

endmodule

`default_nettype wire

// ----- sv/triangle_raster_interpolator.sv -----
// ----------------------------------------------------------------------------
// Triangle raster interpolator
// Scans a triangle's bounding box over a grid store and writes the
// barycentric interpolation of the vertex attribute into inside cells.
// ----------------------------------------------------------------------------
// After reset the block sweeps the grid store to zero, one cell per cycle,
// and stalls requests meanwhile. A read request passes the read, read-data
// and done states. A draw request first runs four floor divisions for the
// bounding box and up to twelve setup products on one shift-and-add
// multiplier, stopping after the determinant if it is zero or the box is
// empty, then steps through the box, skipping cells outside the triangle;
// each inside cell waits for the 32-step weight dividers and the three
// attribute products before it is written. One request is in work at a
// time; the result waits in an output register while the next request is taken.
`default_nettype none

module triangle_raster_interpolator #(
    parameter int GRID_COLS = trast_pkg::GRID_COLS_DEF,
    parameter int GRID_ROWS = trast_pkg::GRID_ROWS_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_operation,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vx0,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vy0,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vx1,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vy1,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vx2,
    input  wire logic signed [trast_pkg::COORD_W-1:0] i_vy2,
    input  wire logic signed [trast_pkg::ATTR_W-1:0]  i_attr0,
    input  wire logic signed [trast_pkg::ATTR_W-1:0]  i_attr1,
    input  wire logic signed [trast_pkg::ATTR_W-1:0]  i_attr2,
    input  wire logic        [trast_pkg::IDX_W-1:0]   i_read_col,
    input  wire logic        [trast_pkg::IDX_W-1:0]   i_read_row,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed      [trast_pkg::ATTR_W-1:0]  o_cell_value,
    output logic             [trast_pkg::CNT_W-1:0]   o_cells_written,
    output logic                                     o_clipped,
    output logic signed      [trast_pkg::ATTR_W-1:0]  o_value_min,
    output logic signed      [trast_pkg::ATTR_W-1:0]  o_value_max,
    output logic                                     o_range_valid,
    input  wire logic                                i_cfg_we,
    input  wire logic        [trast_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic        [trast_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import trast_pkg::*;

    localparam int CW    = $clog2(GRID_COLS);
    localparam int RW    = $clog2(GRID_ROWS);
    localparam int DEPTH = GRID_COLS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM_W = 13;
    localparam logic signed [QUO_W-1:0] COL_MAX = QUO_W'(GRID_COLS - 1);
    localparam logic signed [QUO_W-1:0] ROW_MAX = QUO_W'(GRID_ROWS - 1);

    typedef enum logic [11:0] {
        S_CLEAR = 12'b0000_0000_0001,
        S_IDLE  = 12'b0000_0000_0010,
        S_BBOX  = 12'b0000_0000_0100,
        S_SETUP = 12'b0000_0000_1000,
        S_FLIP  = 12'b0000_0001_0000,
        S_SCAN  = 12'b0000_0010_0000,
        S_FRAC  = 12'b0000_0100_0000,
        S_VAL   = 12'b0000_1000_0000,
        S_WRITE = 12'b0001_0000_0000,
        S_READ  = 12'b0010_0000_0000,
        S_RDATA = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } t_state;

    typedef enum logic [3:0] {
        J_DET_A = 4'd0,
        J_DET_B = 4'd1,
        J_DUX   = 4'd2,
        J_DVX   = 4'd3,
        J_DUY   = 4'd4,
        J_DVY   = 4'd5,
        J_TX    = 4'd6,
        J_TY    = 4'd7,
        J_U_A   = 4'd8,
        J_U_B   = 4'd9,
        J_V_A   = 4'd10,
        J_V_B   = 4'd11
    } t_job;

    function automatic logic signed [COORD_W-1:0] f_min3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a < b) ? a : b;
        return (m < c) ? m : c;
    endfunction

    function automatic logic signed [COORD_W-1:0] f_max3(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b,
        input logic signed [COORD_W-1:0] c
    );
        logic signed [COORD_W-1:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    t_state r_state;
    t_job   r_job;
    logic   r_go;
    logic [1:0] r_bj;
    logic [AW-1:0] r_clr;

    logic signed [COORD_W-1:0] r_org_x, r_org_y;
    logic [CELL_W-1:0]         r_cdx, r_cdy;

    logic                      r_op;
    logic signed [COORD_W-1:0] r_x0, r_y0;
    logic signed [COORD_W-1:0] r_minx, r_maxx, r_miny, r_maxy;
    logic signed [DIFF_W-1:0]  r_d1x, r_d1y, r_d2x, r_d2y;
    logic signed [ATTR_W-1:0]  r_a0, r_a1, r_a2;
    logic [IDX_W-1:0]          r_col, r_row;

    logic [CW-1:0] r_lox, r_hix, r_gx;
    logic [RW-1:0] r_loy, r_hiy, r_gy;
    logic          r_empty, r_clip;

    logic signed [GEO_W-1:0] r_det, r_u, r_v, r_urow, r_vrow;
    logic signed [GEO_W-1:0] r_dux, r_dvx, r_duy, r_dvy, r_tx, r_ty;

    logic [FRAC_W-1:0]  r_wu, r_wv;
    logic [1:0]         r_k;
    logic signed [63:0] r_prod;
    logic [63:0]        r_acc;

    logic [CNT_W-1:0]          r_cnt;
    logic signed [ATTR_W-1:0]  r_min, r_max;
    logic                      r_seen;
    logic signed [ATTR_W-1:0]  r_rdval;

    logic                      r_ovalid;
    logic signed [ATTR_W-1:0]  r_o_val, r_o_min, r_o_max;
    logic [CNT_W-1:0]          r_o_cnt;
    logic                      r_o_clip, r_o_seen;

    logic [CSZ_W-1:0] w_cx, w_cy;
    logic             w_accept;

    logic                      w_div_start, w_div_done;
    logic signed [DVD_W-1:0]   w_dvd;
    logic [CSZ_W-1:0]          w_dvs;
    logic signed [QUO_W-1:0]   w_quo, w_raw, w_lim;

    logic                      w_mul_start, w_mul_done;
    logic signed [MA_W-1:0]    w_ma;
    logic signed [MB_W-1:0]    w_mb;
    logic signed [GEO_W-1:0]   w_mp, w_det_b;

    logic                      w_inside, w_frac_start;
    logic                      w_fu_done, w_fv_done;
    logic [FRAC_W-1:0]         w_fu, w_fv;

    logic [FRAC_W:0]           w_wo;
    logic signed [ATTR_W-1:0]  w_va;
    logic [FRAC_W:0]           w_vw;
    logic signed [65:0]        w_pfull;
    logic signed [ATTR_W-1:0]  w_val;

    logic          w_advance, w_last_col, w_last_row;
    logic          w_rd_in;
    logic [AW-1:0] w_rd_addr, w_wr_addr, w_waddr;
    logic          w_we;
    logic [ATTR_W-1:0] w_wdata, w_rdata;

    assign w_cx = {((r_cdx == '0) ? CELL_W'(1) : r_cdx), 8'h00};
    assign w_cy = {((r_cdy == '0) ? CELL_W'(1) : r_cdy), 8'h00};

    assign o_stall  = (r_state != S_IDLE);
    assign w_accept = i_valid && !o_stall;

    // bounding box divisions
    always_comb begin
        unique case (r_bj)
            2'd0:    w_dvd = DVD_W'(r_minx) - DVD_W'(r_org_x);
            2'd1:    w_dvd = DVD_W'(r_maxx) - DVD_W'(r_org_x);
            2'd2:    w_dvd = DVD_W'(r_miny) - DVD_W'(r_org_y);
            default: w_dvd = DVD_W'(r_maxy) - DVD_W'(r_org_y);
        endcase
    end

    assign w_dvs       = r_bj[1] ? w_cy : w_cx;
    assign w_div_start = (r_state == S_BBOX) && !r_go;
    assign w_raw       = r_bj[0] ? (w_quo + QUO_W'(1)) : w_quo;
    assign w_lim       = r_bj[1] ? ROW_MAX : COL_MAX;

    trast_fdiv u_fdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_dvd   (w_dvd),
        .i_dvs   (w_dvs),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // setup products
    always_comb begin
        unique case (r_job)
            J_DET_A: begin w_ma = MA_W'(r_d1x); w_mb = MB_W'(r_d2y); end
            J_DET_B: begin w_ma = MA_W'(r_d1y); w_mb = MB_W'(r_d2x); end
            J_DUX:   begin w_ma = MA_W'(w_cx);  w_mb = MB_W'(r_d2y); end
            J_DVX:   begin w_ma = MA_W'(w_cx);  w_mb = MB_W'(r_d1y); end
            J_DUY:   begin w_ma = MA_W'(w_cy);  w_mb = MB_W'(r_d2x); end
            J_DVY:   begin w_ma = MA_W'(w_cy);  w_mb = MB_W'(r_d1x); end
            J_TX:    begin w_ma = MA_W'(w_cx);  w_mb = MB_W'(r_lox); end
            J_TY:    begin w_ma = MA_W'(w_cy);  w_mb = MB_W'(r_loy); end
            J_U_A:   begin w_ma = MA_W'(r_tx);  w_mb = MB_W'(r_d2y); end
            J_U_B:   begin w_ma = MA_W'(r_ty);  w_mb = MB_W'(r_d2x); end
            J_V_A:   begin w_ma = MA_W'(r_ty);  w_mb = MB_W'(r_d1x); end
            J_V_B:   begin w_ma = MA_W'(r_tx);  w_mb = MB_W'(r_d1y); end
            default: begin w_ma = '0;           w_mb = '0;           end
        endcase
    end

    assign w_mul_start = (r_state == S_SETUP) && !r_go;
    assign w_det_b     = r_det - w_mp;

    trast_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_ma),
        .i_b     (w_mb),
        .o_done  (w_mul_done),
        .o_p     (w_mp)
    );

    // cell test and weights
    assign w_inside     = (r_u > 0) && (r_v > 0) && ((r_u + r_v) < r_det);
    assign w_frac_start = (r_state == S_SCAN) && w_inside;

    trast_frac u_frac_u (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_frac_start),
        .i_num   (r_u),
        .i_den   (r_det),
        .o_done  (w_fu_done),
        .o_q     (w_fu)
    );

    trast_frac u_frac_v (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_frac_start),
        .i_num   (r_v),
        .i_den   (r_det),
        .o_done  (w_fv_done),
        .o_q     (w_fv)
    );

    assign w_wo = {1'b1, FRAC_W'(0)} - {1'b0, r_wu} - {1'b0, r_wv};

    always_comb begin
        unique case (r_k)
            2'd0:    begin w_va = r_a0; w_vw = w_wo;          end
            2'd1:    begin w_va = r_a1; w_vw = {1'b0, r_wu};  end
            default: begin w_va = r_a2; w_vw = {1'b0, r_wv};  end
        endcase
    end

    assign w_pfull = w_va * $signed({1'b0, w_vw});
    assign w_val   = r_acc[63:32];

    assign w_advance  = ((r_state == S_SCAN) && !w_inside) || (r_state == S_WRITE);
    assign w_last_col = (r_gx == r_hix);
    assign w_last_row = (r_gy == r_hiy);

    // grid store
    assign w_rd_in   = (LIM_W'(r_col) < LIM_W'(GRID_COLS)) &&
                       (LIM_W'(r_row) < LIM_W'(GRID_ROWS));
    assign w_rd_addr = AW'(AW'(r_row) * AW'(GRID_COLS) + AW'(r_col));
    assign w_wr_addr = AW'(AW'(r_gy) * AW'(GRID_COLS) + AW'(r_gx));
    assign w_we      = (r_state == S_CLEAR) || (r_state == S_WRITE);
    assign w_waddr   = (r_state == S_CLEAR) ? r_clr : w_wr_addr;
    assign w_wdata   = (r_state == S_CLEAR) ? '0 : w_val;

    trast_ram #(
        .WIDTH (ATTR_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_go     <= 1'b0;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_cdx    <= CELL_W'(1);
            r_cdy    <= CELL_W'(1);
            r_min    <= {1'b0, {(ATTR_W-1){1'b1}}};
            r_max    <= {1'b1, {(ATTR_W-1){1'b0}}};
            r_seen   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_idx))
                    CFG_ORIGIN_X: r_org_x <= i_cfg_wdata;
                    CFG_ORIGIN_Y: r_org_y <= i_cfg_wdata;
                    CFG_CELL_DX:  r_cdx   <= i_cfg_wdata[CELL_W-1:0];
                    CFG_CELL_DY:  r_cdy   <= i_cfg_wdata[CELL_W-1:0];
                    default: ;
                endcase
            end

            if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_op    <= i_operation;
                        r_x0    <= i_vx0;
                        r_y0    <= i_vy0;
                        r_minx  <= f_min3(i_vx0, i_vx1, i_vx2);
                        r_maxx  <= f_max3(i_vx0, i_vx1, i_vx2);
                        r_miny  <= f_min3(i_vy0, i_vy1, i_vy2);
                        r_maxy  <= f_max3(i_vy0, i_vy1, i_vy2);
                        r_d1x   <= DIFF_W'(i_vx1) - DIFF_W'(i_vx0);
                        r_d1y   <= DIFF_W'(i_vy1) - DIFF_W'(i_vy0);
                        r_d2x   <= DIFF_W'(i_vx2) - DIFF_W'(i_vx0);
                        r_d2y   <= DIFF_W'(i_vy2) - DIFF_W'(i_vy0);
                        r_a0    <= i_attr0;
                        r_a1    <= i_attr1;
                        r_a2    <= i_attr2;
                        r_col   <= i_read_col;
                        r_row   <= i_read_row;
                        r_cnt   <= '0;
                        r_clip  <= 1'b0;
                        r_empty <= 1'b0;
                        r_bj    <= '0;
                        r_job   <= J_DET_A;
                        r_go    <= 1'b0;
                        r_state <= (i_operation == OP_READ) ? S_READ : S_BBOX;
                    end
                end
                S_BBOX: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_div_done) begin
                        r_go <= 1'b0;
                        r_bj <= r_bj + 2'd1;
                        if (!r_bj[0]) begin
                            // low edge of the box
                            if (w_raw < 0) r_clip <= 1'b1;
                            if (w_raw > w_lim) r_empty <= 1'b1;
                            if (r_bj[1]) begin
                                r_loy <= (w_raw < 0) ? '0 : RW'(w_raw);
                            end else begin
                                r_lox <= (w_raw < 0) ? '0 : CW'(w_raw);
                            end
                        end else begin
                            // high edge of the box
                            if (w_raw > w_lim) r_clip <= 1'b1;
                            if (w_raw < 0) r_empty <= 1'b1;
                            if (r_bj[1]) begin
                                r_hiy <= (w_raw > w_lim) ? RW'(w_lim) : RW'(w_raw);
                            end else begin
                                r_hix <= (w_raw > w_lim) ? CW'(w_lim) : CW'(w_raw);
                            end
                        end
                        if (r_bj == 2'd3) begin
                            r_state <= S_SETUP;
                        end
                    end
                end
                S_SETUP: begin
                    if (!r_go) begin
                        r_go <= 1'b1;
                    end else if (w_mul_done) begin
                        r_go  <= 1'b0;
                        r_job <= t_job'(r_job + 4'd1);
                        unique case (r_job)
                            J_DET_A: r_det <= w_mp;
                            J_DET_B: begin
                                r_det <= w_det_b;
                                if ((w_det_b == '0) || r_empty) begin
                                    r_state <= S_DONE;
                                end
                            end
                            J_DUX:   r_dux <= w_mp;
                            J_DVX:   r_dvx <= -w_mp;
                            J_DUY:   r_duy <= -w_mp;
                            J_DVY:   r_dvy <= w_mp;
                            J_TX:    r_tx  <= w_mp + GEO_W'(r_org_x) - GEO_W'(r_x0);
                            J_TY:    r_ty  <= w_mp + GEO_W'(r_org_y) - GEO_W'(r_y0);
                            J_U_A:   r_u   <= w_mp;
                            J_U_B:   r_u   <= r_u - w_mp;
                            J_V_A:   r_v   <= w_mp;
                            J_V_B: begin
                                r_v     <= r_v - w_mp;
                                r_state <= S_FLIP;
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_FLIP: begin
                    // clockwise triangles: work on negated edge functions
                    if (r_det < 0) begin
                        r_det  <= -r_det;
                        r_u    <= -r_u;
                        r_v    <= -r_v;
                        r_urow <= -r_u;
                        r_vrow <= -r_v;
                        r_dux  <= -r_dux;
                        r_dvx  <= -r_dvx;
                        r_duy  <= -r_duy;
                        r_dvy  <= -r_dvy;
                    end else begin
                        r_urow <= r_u;
                        r_vrow <= r_v;
                    end
                    r_gx    <= r_lox;
                    r_gy    <= r_loy;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    if (w_inside) begin
                        r_state <= S_FRAC;
                    end
                end
                S_FRAC: begin
                    if (w_fu_done && w_fv_done) begin
                        r_wu    <= w_fu;
                        r_wv    <= w_fv;
                        r_k     <= '0;
                        r_state <= S_VAL;
                    end
                end
                S_VAL: begin
                    r_prod <= w_pfull[63:0];
                    r_k    <= r_k + 2'd1;
                    unique case (r_k)
                        2'd0:    r_acc <= 64'h0000_0000_8000_0000;
                        default: r_acc <= r_acc + r_prod;
                    endcase
                    if (r_k == 2'd3) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (r_cnt != {CNT_W{1'b1}}) begin
                        r_cnt <= r_cnt + CNT_W'(1);
                    end
                    if (w_val != '0) begin
                        if (w_val < r_min) r_min <= w_val;
                        if (w_val > r_max) r_max <= w_val;
                        r_seen <= 1'b1;
                    end
                    r_state <= S_SCAN;
                end
                S_READ: begin
                    r_clip  <= !w_rd_in;
                    r_state <= S_RDATA;
                end
                S_RDATA: begin
                    r_rdval <= r_clip ? '0 : w_rdata;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_ovalid || !i_stall) begin
                        r_ovalid <= 1'b1;
                        r_o_val  <= (r_op == OP_READ) ? r_rdval : '0;
                        r_o_cnt  <= r_cnt;
                        r_o_clip <= r_clip;
                        r_o_min  <= r_min;
                        r_o_max  <= r_max;
                        r_o_seen <= r_seen;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_advance) begin
                if (w_last_col) begin
                    if (w_last_row) begin
                        r_state <= S_DONE;
                    end else begin
                        r_gy   <= r_gy + RW'(1);
                        r_gx   <= r_lox;
                        r_urow <= r_urow + r_duy;
                        r_vrow <= r_vrow + r_dvy;
                        r_u    <= r_urow + r_duy;
                        r_v    <= r_vrow + r_dvy;
                    end
                end else begin
                    r_gx <= r_gx + CW'(1);
                    r_u  <= r_u + r_dux;
                    r_v  <= r_v + r_dvx;
                end
            end
        end
    end

    assign o_valid         = r_ovalid;
    assign o_cell_value    = r_o_val;
    assign o_cells_written = r_o_cnt;
    assign o_clipped       = r_o_clip;
    assign o_value_min     = r_o_min;
    assign o_value_max     = r_o_max;
    assign o_range_valid   = r_o_seen;

endmodule

`default_nettype wire

// ----- sim/triangle_raster_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// Triangle raster interpolator testbench
// Drives draw and read requests with bursty valid and a patterned stall,
// predicts every result with an exact integer rasteriser held alongside,
// and compares each result field by field in request order.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_raster_interpolator_tb;
    import trast_pkg::*;

    localparam int NCOLS      = 256;
    localparam int NROWS      = 256;
    localparam int NRAND      = 400;
    localparam int MAX_BOX    = 40;
    localparam int IDLE_LIMIT = 300000;
    localparam int HOLD_LEN   = 2500;

    typedef struct {
        logic                     op;
        logic signed [31:0]       vx0, vy0, vx1, vy1, vx2, vy2;
        logic signed [31:0]       attr0, attr1, attr2;
        logic [7:0]               col, row;
    } raster_req_t;

    typedef struct {
        logic signed [31:0] cval;
        logic [16:0]        cnt;
        logic               clip;
        logic signed [31:0] vmin, vmax;
        logic               rv;
    } raster_res_t;

    typedef struct {
        raster_req_t req;
        bit          has_exp;
        raster_res_t exp;
    } dir_row_t;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic i_operation;
    logic signed [31:0] i_vx0, i_vy0, i_vx1, i_vy1, i_vx2, i_vy2;
    logic signed [31:0] i_attr0, i_attr1, i_attr2;
    logic [7:0] i_read_col, i_read_row;
    logic signed [31:0] o_cell_value, o_value_min, o_value_max;
    logic [16:0] o_cells_written;
    logic o_clipped, o_range_valid;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0] i_cfg_wdata;

    triangle_raster_interpolator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_operation(i_operation),
        .i_vx0(i_vx0), .i_vy0(i_vy0), .i_vx1(i_vx1), .i_vy1(i_vy1),
        .i_vx2(i_vx2), .i_vy2(i_vy2),
        .i_attr0(i_attr0), .i_attr1(i_attr1), .i_attr2(i_attr2),
        .i_read_col(i_read_col), .i_read_row(i_read_row),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_cell_value(o_cell_value), .o_cells_written(o_cells_written),
        .o_clipped(o_clipped), .o_value_min(o_value_min),
        .o_value_max(o_value_max), .o_range_valid(o_range_valid),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    // shadow state
    logic [31:0]  cell_mem [NROWS*NCOLS];
    longint       run_min, run_max;
    bit           run_seen;
    longint       org_x, org_y, step_x, step_y;

    raster_res_t  pending_res[$];
    int           written_cells[$];
    int           n_errors;
    int           idle_cycles;
    bit           hold_req;
    int           burst_left;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic longint floor_div(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q--;
        return q;
    endfunction

    function automatic longint min3(longint a, longint b, longint c);
        longint m;
        m = a < b ? a : b;
        return m < c ? m : c;
    endfunction

    function automatic longint max3(longint a, longint b, longint c);
        longint m;
        m = a > b ? a : b;
        return m > c ? m : c;
    endfunction

    // clamped bounding box under the current cell setup
    function automatic void bbox(input raster_req_t r, output longint lx, output longint hx,
                                 output longint ly, output longint hy, output bit clip);
        longint cx, cy;
        cx = (step_x == 0 ? 1 : step_x) * 256;
        cy = (step_y == 0 ? 1 : step_y) * 256;
        lx = floor_div(min3(r.vx0, r.vx1, r.vx2) - org_x, cx);
        hx = floor_div(max3(r.vx0, r.vx1, r.vx2) - org_x, cx) + 1;
        ly = floor_div(min3(r.vy0, r.vy1, r.vy2) - org_y, cy);
        hy = floor_div(max3(r.vy0, r.vy1, r.vy2) - org_y, cy) + 1;
        clip = (lx < 0 || ly < 0 || hx >= NCOLS || hy >= NROWS);
        if (lx < 0) lx = 0;
        if (ly < 0) ly = 0;
        if (hx > NCOLS-1) hx = NCOLS-1;
        if (hy > NROWS-1) hy = NROWS-1;
    endfunction

    function automatic longint box_cells(raster_req_t r);
        longint lx, hx, ly, hy;
        bit clip;
        bbox(r, lx, hx, ly, hy, clip);
        if (hx < lx || hy < ly) return 0;
        return (hx - lx + 1) * (hy - ly + 1);
    endfunction

    function automatic raster_res_t raster_predict(raster_req_t r);
        raster_res_t res;
        longint lx, hx, ly, hy, cx, cy, gx, gy, val;
        longint a0, a1, a2;
        bit clip, flip;
        logic signed [127:0] d1x, d1y, d2x, d2y, det, tx, ty, u, v;
        logic [63:0] wu, wv, wo, acc;
        logic [31:0] s;
        res = '{default: '0};
        if (r.op == OP_READ) begin
            res.cval = cell_mem[int'(r.row) * NCOLS + int'(r.col)];
        end else begin
            bbox(r, lx, hx, ly, hy, clip);
            res.clip = clip;
            cx = (step_x == 0 ? 1 : step_x) * 256;
            cy = (step_y == 0 ? 1 : step_y) * 256;
            a0 = r.attr0; a1 = r.attr1; a2 = r.attr2;
            d1x = longint'(r.vx1) - longint'(r.vx0);
            d1y = longint'(r.vy1) - longint'(r.vy0);
            d2x = longint'(r.vx2) - longint'(r.vx0);
            d2y = longint'(r.vy2) - longint'(r.vy0);
            det = d1x * d2y - d1y * d2x;
            flip = det < 0;
            if (flip) det = -det;
            if (det != 0) begin
                for (gy = ly; gy <= hy; gy++) begin
                    for (gx = lx; gx <= hx; gx++) begin
                        tx = gx * cx + org_x - longint'(r.vx0);
                        ty = gy * cy + org_y - longint'(r.vy0);
                        u = tx * d2y - ty * d2x;
                        v = d1x * ty - d1y * tx;
                        if (flip) begin
                            u = -u;
                            v = -v;
                        end
                        if (u <= 0 || v <= 0 || u + v >= det) continue;
                        wu = 64'((u <<< 32) / det);
                        wv = 64'((v <<< 32) / det);
                        wo = 64'h1_0000_0000 - wu - wv;
                        acc = 64'(a0) * wo + 64'(a1) * wu + 64'(a2) * wv + 64'h8000_0000;
                        s = acc[63:32];
                        cell_mem[gy * NCOLS + gx] = s;
                        written_cells.push_back(int'(gy * NCOLS + gx));
                        if (res.cnt != 17'h1FFFF) res.cnt++;
                        val = longint'(signed'(s));
                        if (val != 0) begin
                            if (val < run_min) run_min = val;
                            if (val > run_max) run_max = val;
                            run_seen = 1'b1;
                        end
                    end
                end
            end
        end
        res.vmin = run_min[31:0];
        res.vmax = run_max[31:0];
        res.rv   = run_seen;
        return res;
    endfunction

    function automatic raster_req_t mk_read(int c, int r);
        raster_req_t q;
        q = '{default: '0};
        q.op = OP_READ;
        q.col = c[7:0];
        q.row = r[7:0];
        return q;
    endfunction

    function automatic raster_req_t mk_draw(longint x0, longint y0, longint x1, longint y1,
                                            longint x2, longint y2,
                                            longint a0, longint a1, longint a2);
        raster_req_t q;
        q = '{default: '0};
        q.op = OP_DRAW;
        q.vx0 = x0[31:0]; q.vy0 = y0[31:0];
        q.vx1 = x1[31:0]; q.vy1 = y1[31:0];
        q.vx2 = x2[31:0]; q.vy2 = y2[31:0];
        q.attr0 = a0[31:0]; q.attr1 = a1[31:0]; q.attr2 = a2[31:0];
        q.col = $urandom;
        q.row = $urandom;
        return q;
    endfunction

    // a small triangle near the grid, or now and then a wild one
    function automatic raster_req_t gen_draw();
        raster_req_t q;
        longint cx, cy, bx, by;
        for (int tries = 0; tries < 40; tries++) begin
            if (tries < 30 && $urandom_range(0, 9) == 0) begin
                q = mk_draw($urandom, $urandom, $urandom, $urandom, $urandom,
                            $urandom, $urandom, $urandom, $urandom);
            end else begin
                cx = (step_x == 0 ? 1 : step_x) * 256;
                cy = (step_y == 0 ? 1 : step_y) * 256;
                bx = org_x + (longint'($urandom_range(0, 260)) - 2) * cx;
                by = org_y + (longint'($urandom_range(0, 260)) - 2) * cy;
                q = mk_draw(bx + $urandom_range(0, 3 * cx), by + $urandom_range(0, 3 * cy),
                            bx + $urandom_range(0, 3 * cx), by + $urandom_range(0, 3 * cy),
                            bx + $urandom_range(0, 3 * cx), by + $urandom_range(0, 3 * cy),
                            $urandom, $urandom, $urandom);
                if ($urandom_range(0, 7) == 0) q.attr1 = q.attr0;
            end
            if (box_cells(q) <= MAX_BOX) return q;
        end
        return mk_draw(32'sh8000_0000, 0, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 1, 2, 3);
    endfunction

    function automatic raster_req_t gen_read();
        int k;
        if (written_cells.size() > 0 && $urandom_range(0, 3) != 0) begin
            k = written_cells[$urandom_range(0, written_cells.size() - 1)];
            return mk_read(k % NCOLS, k / NCOLS);
        end
        return mk_read($urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // offer one request and wait for it to be taken
    task automatic send_req(raster_req_t r, bit has_exp, raster_res_t exp);
        raster_res_t p;
        i_valid     <= 1'b1;
        i_operation <= r.op;
        i_vx0 <= r.vx0; i_vy0 <= r.vy0;
        i_vx1 <= r.vx1; i_vy1 <= r.vy1;
        i_vx2 <= r.vx2; i_vy2 <= r.vy2;
        i_attr0 <= r.attr0; i_attr1 <= r.attr1; i_attr2 <= r.attr2;
        i_read_col <= r.col;
        i_read_row <= r.row;
        do @(posedge i_clk); while (o_stall);
        p = raster_predict(r);
        pending_res.push_back(has_exp ? exp : p);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            if ($urandom_range(0, 3) != 0) begin
                i_valid <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_cfg(t_cfg_reg idx, logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_ORIGIN_X: org_x  = longint'(signed'(data));
            CFG_ORIGIN_Y: org_y  = longint'(signed'(data));
            CFG_CELL_DX:  step_x = data[15:0];
            CFG_CELL_DY:  step_y = data[15:0];
            default: ;
        endcase
    endtask

    task automatic set_grid(logic [31:0] ox, logic [31:0] oy, logic [15:0] dx,
                            logic [15:0] dy);
        write_cfg(CFG_ORIGIN_X, ox);
        write_cfg(CFG_ORIGIN_Y, oy);
        write_cfg(CFG_CELL_DX, {16'h0, dx});
        write_cfg(CFG_CELL_DY, {16'h0, dy});
        @(posedge i_clk);
    endtask

    // receiver: stall pattern, one long hold-off, result checking
    int          stall_mode, mode_left, hold_cnt;
    bit          hold_done;
    raster_res_t want;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_res.size() == 0) begin
                $display("%0t: result with nothing expected, value %h", $time, o_cell_value);
                n_errors++;
            end else begin
                want = pending_res.pop_front();
                if (o_cell_value !== want.cval || o_cells_written !== want.cnt ||
                    o_clipped !== want.clip || o_value_min !== want.vmin ||
                    o_value_max !== want.vmax || o_range_valid !== want.rv) begin
                    $display("%0t: mismatch exp val=%h cnt=%0d clip=%b min=%h max=%h rv=%b",
                             $time, want.cval, want.cnt, want.clip, want.vmin, want.vmax,
                             want.rv);
                    $display("%0t:          got val=%h cnt=%0d clip=%b min=%h max=%h rv=%b",
                             $time, o_cell_value, o_cells_written, o_clipped, o_value_min,
                             o_value_max, o_range_valid);
                    n_errors++;
                end
            end
        end
        if (hold_req && !hold_done) begin
            i_stall <= 1'b1;
            hold_cnt++;
            if (hold_cnt >= HOLD_LEN) hold_done = 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(20, 300);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0: i_stall <= 1'b0;
                1: i_stall <= ($urandom_range(0, 9) < 3);
                default: i_stall <= ~i_stall;
            endcase
        end
    end

    // watchdog on progress
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    dir_row_t    dir_tab[$];
    raster_res_t blank;
    raster_req_t rq;

    task automatic add_row(raster_req_t r, bit has_exp, raster_res_t e);
        dir_row_t d;
        d.req = r;
        d.has_exp = has_exp;
        d.exp = e;
        dir_tab.push_back(d);
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0; i_stall = 1'b0; i_operation = OP_DRAW;
        {i_vx0, i_vy0, i_vx1, i_vy1, i_vx2, i_vy2} = '0;
        {i_attr0, i_attr1, i_attr2} = '0;
        i_read_col = '0; i_read_row = '0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_ORIGIN_X; i_cfg_wdata = '0;
        n_errors = 0; idle_cycles = 0; hold_req = 1'b0; hold_done = 1'b0;
        hold_cnt = 0; stall_mode = 0; mode_left = 0; burst_left = 0;
        foreach (cell_mem[k]) cell_mem[k] = '0;
        run_min = 64'sh7FFF_FFFF;
        run_max = -64'sh8000_0000;
        run_seen = 1'b0;
        org_x = 0; org_y = 0; step_x = 1; step_y = 1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset-state expectation: empty store, range at its reset values
        blank = '{cval: 32'h0, cnt: 17'h0, clip: 1'b0, vmin: 32'h7FFF_FFFF,
                  vmax: 32'h8000_0000, rv: 1'b0};
        add_row(mk_read(0, 0), 1, blank);
        add_row(mk_read(255, 255), 1, blank);
        add_row(mk_read(255, 0), 1, blank);
        begin
            raster_res_t e;
            e = blank;
            e.clip = 1'b1;
            add_row(mk_draw(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 0), 1, e);
            add_row(mk_draw(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'shFFFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000), 1, e);
            // degenerate: collinear vertices inside the grid
            add_row(mk_draw(256, 256, 512, 512, 768, 768, 1 << 16, 2 << 16, 3 << 16), 1,
                    blank);
        end
        // zero attributes: cells written, range untouched
        add_row(mk_draw(2560, 2560, 5120, 2560, 2560, 5120, 0, 0, 0), 0, blank);
        add_row(mk_read(11, 11), 0, blank);
        // extreme attributes, both windings
        add_row(mk_draw(256, 256, 1792, 256, 256, 1792, 32'sh7FFF_FFFF, 32'sh8000_0000,
                        0), 0, blank);
        add_row(mk_draw(256, 256, 256, 1792, 1792, 256, 32'sh8000_0000, 32'sh8000_0000,
                        32'sh7FFF_FFFF), 0, blank);
        add_row(mk_read(2, 2), 0, blank);
        add_row(mk_read(3, 2), 0, blank);
        // box crossing the low and the high grid edges
        add_row(mk_draw(-512, -512, 1024, -256, -128, 1280, 1 << 16, -(1 << 16), 5), 0,
                blank);
        add_row(mk_draw(65024, 65024, 65792, 64768, 64900, 66000, 7, 8, 9), 0, blank);
        add_row(mk_read(254, 254), 0, blank);
        add_row(mk_read(0, 1), 0, blank);

        foreach (dir_tab[k]) send_req(dir_tab[k].req, dir_tab[k].has_exp, dir_tab[k].exp);
        drain();

        // zero cell size is taken as one; odd origin with fraction bits
        set_grid(32'hFFFF_FF80, 32'h0000_0140, 16'h0, 16'h0);
        add_row(mk_draw(0, 0, 1280, 128, 300, 1300, 3 << 16, -(4 << 16), 12345), 0,
                blank);
        for (int k = dir_tab.size() - 1; k < dir_tab.size(); k++)
            send_req(dir_tab[k].req, 0, blank);
        send_req(mk_read(2, 1), 0, blank);
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: set_grid(0, 0, 16'd1, 16'd1);
                1: set_grid($urandom, $urandom, $urandom_range(1, 8), $urandom_range(1, 8));
                2: set_grid(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 16'hFFFF);
                3: set_grid(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd1, 16'hFFFF);
                4: set_grid($urandom, $urandom, $urandom, $urandom);
                default: set_grid($urandom_range(0, 4095), $urandom_range(0, 4095),
                                  16'd2, 16'd3);
            endcase
            for (int n = 0; n < NRAND / 6; n++) begin
                if (ph == 1 && n == 20) hold_req = 1'b1;
                if ($urandom_range(0, 2) == 0) rq = gen_read();
                else rq = gen_draw();
                send_req(rq, 0, blank);
            end
            drain();
        end

        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
